// ===== hw/rtl/mtcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtcc_pkg
// Shared types and codes for the multi-axis task completion controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mtcc_pkg;

    // item kinds carried in tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // task identifiers
    localparam logic [2:0] TASK_DRIVE   = 3'd0;
    localparam logic [2:0] TASK_CLAW    = 3'd1;
    localparam logic [2:0] TASK_TIGHTEN = 3'd2;
    localparam logic [2:0] TASK_ARM     = 3'd3;
    localparam logic [2:0] TASK_HEADING = 3'd4;

    localparam int unsigned NUM_TASKS = 5;

    // configuration register indexes
    localparam logic [2:0] CFG_CLAW_THRESHOLD    = 3'd0;
    localparam logic [2:0] CFG_ARM_THRESHOLD     = 3'd1;
    localparam logic [2:0] CFG_HEADING_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_CLAW_FULL_SPEED   = 3'd3;
    localparam logic [2:0] CFG_LIFT_FULL_SPEED   = 3'd4;
    localparam logic [2:0] CFG_TURN_FULL_SPEED   = 3'd5;
    localparam logic [2:0] CFG_CLAW_CLOSED_POS   = 3'd6;

    // motor command codes
    typedef enum logic [1:0] {
        CLAW_NONE  = 2'd0,
        CLAW_OPEN  = 2'd1,
        CLAW_CLOSE = 2'd2,
        CLAW_STOP  = 2'd3
    } claw_act_t;

    typedef enum logic [1:0] {
        ARM_NONE = 2'd0,
        ARM_LIFT = 2'd1,
        ARM_DROP = 2'd2,
        ARM_STOP = 2'd3
    } arm_act_t;

    typedef enum logic [1:0] {
        TURN_NONE = 2'd0,
        TURN_CW   = 2'd1,
        TURN_CCW  = 2'd2
    } turn_act_t;

    // distance band limits
    localparam logic [16:0] CLAW_BAND_FINE   = 17'd250;
    localparam logic [16:0] CLAW_BAND_MID    = 17'd500;
    localparam logic [16:0] CLAW_BAND_COARSE = 17'd1000;
    localparam logic [16:0] ARM_BAND_FINE    = 17'd500;
    localparam logic [16:0] ARM_BAND_COARSE  = 17'd1000;
    localparam logic [16:0] TURN_BAND_FINE   = 17'd300;
    localparam logic [16:0] TURN_BAND_COARSE = 17'd600;
    localparam logic [16:0] STALL_LIMIT      = 17'd5;

    typedef struct packed {
        logic [11:0]        claw_threshold;
        logic [11:0]        arm_threshold;
        logic [11:0]        heading_threshold;
        logic [6:0]         claw_full_speed;
        logic [6:0]         lift_full_speed;
        logic [6:0]         turn_full_speed;
        logic signed [15:0] claw_shut_pos;
    } mtcc_cfg_t;

    typedef struct packed {
        logic               opcode;
        logic [2:0]         task_id;
        logic signed [15:0] task_target;
        logic signed [15:0] drive_encoder;
        logic signed [15:0] claw_sensor;
        logic signed [15:0] arm_sensor;
        logic signed [15:0] heading_sensor;
    } mtcc_item_t;

    typedef struct packed {
        logic       drive_stop;
        logic       encoder_reset;
        logic [1:0] claw_action;
        logic [6:0] claw_drive_speed;
        logic [1:0] arm_action;
        logic [6:0] arm_drive_speed;
        logic [1:0] turn_action;
        logic [6:0] turn_drive_speed;
        logic [4:0] active_tasks;
        logic       all_done;
    } mtcc_result_t;

    // difference of two 16-bit readings, exact in 17 bits
    function automatic logic signed [16:0] diff17(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
        diff17 = {a[15], a} - {b[15], b};
    endfunction

    // magnitude of a 17-bit difference, unsigned
    function automatic logic [16:0] mag17(input logic signed [16:0] v);
        mag17 = v[16] ? (17'd0 - v) : v;
    endfunction

    // truncating divide by three for a 7-bit speed (exact for every 7-bit input)
    function automatic logic [6:0] div3(input logic [6:0] v);
        logic [15:0] prod;
        prod = {9'd0, v} * 16'd171;
        div3 = {1'b0, prod[14:9]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mtcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mtcc_cfg_regs
// Configuration register file: thresholds, full speeds and closed position.
// ----------------------------------------------------------------------------
`default_nettype none

module mtcc_cfg_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata,
    output mtcc_pkg::mtcc_cfg_t     cfg
);
    import mtcc_pkg::*;

    mtcc_cfg_t cfg_reg;
    mtcc_cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLAW_THRESHOLD:    cfg_next.claw_threshold       = cfg_wdata[11:0];
                CFG_ARM_THRESHOLD:     cfg_next.arm_threshold        = cfg_wdata[11:0];
                CFG_HEADING_THRESHOLD: cfg_next.heading_threshold    = cfg_wdata[11:0];
                CFG_CLAW_FULL_SPEED:   cfg_next.claw_full_speed      = cfg_wdata[6:0];
                CFG_LIFT_FULL_SPEED:   cfg_next.lift_full_speed      = cfg_wdata[6:0];
                CFG_TURN_FULL_SPEED:   cfg_next.turn_full_speed      = cfg_wdata[6:0];
                CFG_CLAW_CLOSED_POS:   cfg_next.claw_shut_pos        = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage with reset defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.claw_threshold       <= 12'd50;
            cfg_reg.arm_threshold        <= 12'd50;
            cfg_reg.heading_threshold    <= 12'd20;
            cfg_reg.claw_full_speed      <= 7'd127;
            cfg_reg.lift_full_speed      <= 7'd127;
            cfg_reg.turn_full_speed      <= 7'd127;
            cfg_reg.claw_shut_pos        <= 16'sd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mtcc_tracker.sv =====
// ----------------------------------------------------------------------------
// mtcc_tracker
// Task state and the per-item evaluation of all five tasks in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mtcc_tracker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire mtcc_pkg::mtcc_item_t item,
    input  wire mtcc_pkg::mtcc_cfg_t  cfg,
    output mtcc_pkg::mtcc_result_t    result
);
    import mtcc_pkg::*;

    logic [NUM_TASKS-1:0] active_reg, active_next;
    logic signed [15:0]   drive_target_reg, drive_target_next;
    logic signed [15:0]   claw_target_reg, claw_target_next;
    logic signed [15:0]   arm_target_reg, arm_target_next;
    logic signed [15:0]   heading_target_reg, heading_target_next;
    logic signed [15:0]   last_claw_reg, last_claw_next;

    // drive distance check
    logic drive_reached;
    assign drive_reached =
        ((drive_target_reg > 16'sd0) && (item.drive_encoder > drive_target_reg)) ||
        ((drive_target_reg < 16'sd0) && (item.drive_encoder < drive_target_reg));

    // claw position error and band speed
    logic signed [16:0] claw_err;
    logic [16:0]        claw_mag;
    logic               claw_far;
    logic [6:0]         claw_speed;
    assign claw_err = diff17(claw_target_reg, item.claw_sensor);
    assign claw_mag = mag17(claw_err);
    assign claw_far = claw_mag > {5'd0, cfg.claw_threshold};

    always_comb
    begin
        if (claw_mag < CLAW_BAND_FINE)
            claw_speed = cfg.claw_full_speed >> 3;
        else if (claw_mag < CLAW_BAND_MID)
            claw_speed = cfg.claw_full_speed >> 2;
        else if (claw_mag < CLAW_BAND_COARSE)
            claw_speed = cfg.claw_full_speed >> 1;
        else
            claw_speed = cfg.claw_full_speed;
    end

    // tightening: stall or near the closed position
    logic tight_done;
    assign tight_done =
        (mag17(diff17(last_claw_reg, item.claw_sensor)) <= STALL_LIMIT) ||
        (mag17(diff17(item.claw_sensor, cfg.claw_shut_pos)) <
         {5'd0, cfg.claw_threshold});

    // arm error, direction-dependent base speed and bands
    logic signed [16:0] arm_err;
    logic [16:0]        arm_mag;
    logic               arm_far;
    logic               arm_up;
    logic [6:0]         arm_base;
    logic [6:0]         arm_speed;
    assign arm_err  = diff17(arm_target_reg, item.arm_sensor);
    assign arm_mag  = mag17(arm_err);
    assign arm_far  = arm_mag > {5'd0, cfg.arm_threshold};
    assign arm_up   = (arm_err > 17'sd0);
    assign arm_base = arm_up ? cfg.lift_full_speed : div3(cfg.lift_full_speed);

    always_comb
    begin
        if (arm_mag < ARM_BAND_FINE)
            arm_speed = div3(arm_base);
        else if (arm_mag < ARM_BAND_COARSE)
            arm_speed = arm_base >> 1;
        else
            arm_speed = arm_base;
    end

    // heading error and band speed
    logic signed [16:0] head_err;
    logic [16:0]        head_mag;
    logic               head_far;
    logic [6:0]         turn_speed;
    assign head_err = diff17(heading_target_reg, item.heading_sensor);
    assign head_mag = mag17(head_err);
    assign head_far = head_mag > {5'd0, cfg.heading_threshold};

    always_comb
    begin
        if (head_mag < TURN_BAND_FINE)
            turn_speed = cfg.turn_full_speed >> 2;
        else if (head_mag < TURN_BAND_COARSE)
            turn_speed = cfg.turn_full_speed >> 1;
        else
            turn_speed = cfg.turn_full_speed;
    end

    // task updates in fixed order and result assembly
    always_comb
    begin
        active_next         = active_reg;
        drive_target_next   = drive_target_reg;
        claw_target_next    = claw_target_reg;
        arm_target_next     = arm_target_reg;
        heading_target_next = heading_target_reg;
        last_claw_next      = last_claw_reg;
        result              = '0;

        if (item.opcode == OP_START)
        begin
            unique case (item.task_id)
                TASK_DRIVE:
                begin
                    active_next[TASK_DRIVE] = 1'b1;
                    drive_target_next       = item.task_target;
                end
                TASK_CLAW:
                begin
                    active_next[TASK_CLAW] = 1'b1;
                    claw_target_next       = item.task_target;
                end
                TASK_TIGHTEN:
                begin
                    active_next[TASK_TIGHTEN] = 1'b1;
                end
                TASK_ARM:
                begin
                    active_next[TASK_ARM] = 1'b1;
                    arm_target_next       = item.task_target;
                end
                TASK_HEADING:
                begin
                    active_next[TASK_HEADING] = 1'b1;
                    heading_target_next       = item.task_target;
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
        else
        begin
            // drive
            if (active_reg[TASK_DRIVE] && drive_reached)
            begin
                result.drive_stop       = 1'b1;
                result.encoder_reset    = 1'b1;
                active_next[TASK_DRIVE] = 1'b0;
                drive_target_next       = 16'sd0;
            end
            // claw position
            if (active_reg[TASK_CLAW])
            begin
                if (claw_far)
                begin
                    result.claw_action      = (claw_err > 17'sd0) ? CLAW_OPEN : CLAW_CLOSE;
                    result.claw_drive_speed = claw_speed;
                end
                else
                begin
                    result.claw_action     = CLAW_STOP;
                    active_next[TASK_CLAW] = 1'b0;
                end
            end
            // claw tightening, overrides claw position once done
            if (active_reg[TASK_TIGHTEN])
            begin
                last_claw_next = item.claw_sensor;
                if (tight_done)
                begin
                    result.claw_action        = CLAW_STOP;
                    result.claw_drive_speed   = 7'd0;
                    last_claw_next            = 16'sd0;
                    active_next[TASK_TIGHTEN] = 1'b0;
                end
            end
            // arm
            if (active_reg[TASK_ARM])
            begin
                if (arm_far)
                begin
                    result.arm_action      = arm_up ? ARM_LIFT : ARM_DROP;
                    result.arm_drive_speed = arm_speed;
                end
                else
                begin
                    result.arm_action     = ARM_STOP;
                    active_next[TASK_ARM] = 1'b0;
                end
            end
            // heading
            if (active_reg[TASK_HEADING])
            begin
                if (head_far)
                begin
                    result.turn_action      = (head_err > 17'sd0) ? TURN_CW : TURN_CCW;
                    result.turn_drive_speed = turn_speed;
                end
                else
                begin
                    result.drive_stop         = 1'b1;
                    active_next[TASK_HEADING] = 1'b0;
                end
            end
        end

        result.active_tasks = active_next;
        result.all_done     = (active_next == '0);
    end

    // task state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg         <= '0;
            drive_target_reg   <= 16'sd0;
            claw_target_reg    <= 16'sd0;
            arm_target_reg     <= 16'sd0;
            heading_target_reg <= 16'sd0;
            last_claw_reg      <= 16'sd0;
        end
        else if (step)
        begin
            active_reg         <= active_next;
            drive_target_reg   <= drive_target_next;
            claw_target_reg    <= claw_target_next;
            arm_target_reg     <= arm_target_next;
            heading_target_reg <= heading_target_next;
            last_claw_reg      <= last_claw_next;
        end
    end

`ifndef SYNTHESIS
    // a finished drive always stops the base
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.encoder_reset |-> result.drive_stop)
        else $error("encoder reset without drive stop");

    // a finished drive leaves a zero target behind
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.encoder_reset |=> drive_target_reg == 16'sd0)
        else $error("drive target not cleared after finish");

    // the reported mask is what the state takes on
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> active_reg == $past(result.active_tasks))
        else $error("active mask does not match reported mask");

    // start items drive no motor
    assert property (@(posedge clk) disable iff (!rst_n)
        step && item.opcode == OP_START |->
            result.claw_action == CLAW_NONE && result.arm_action == ARM_NONE &&
            result.turn_action == TURN_NONE && !result.drive_stop)
        else $error("motor command on a start item");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/multi_axis_task_completion_controller.sv =====
// Path: an accepted item passes the input register, then the result register,
// and its result is held there while the output stalls.
// Throughput: one item per cycle while the output does not stall; all five
// task checks are evaluated in a single pass, input register to result register.
// Reset: rst_n clears all tasks, targets and the last claw reading, and
// loads the configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_axis_task_completion_controller
// Five-task motion completion tracker with stream input and output.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_axis_task_completion_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: task_id[2:0], task_target[18:3], drive_encoder[34:19],
    //        claw_sensor[50:35], arm_sensor[66:51], heading_sensor[82:67]
    input  wire logic [87:0] s_tdata,
    // tuser: opcode[0]
    input  wire logic        s_tuser,
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: drive_stop[0], encoder_reset[1], claw_action[3:2],
    //        claw_drive_speed[10:4], arm_action[12:11], arm_drive_speed[19:13],
    //        turn_action[21:20], turn_drive_speed[28:22], active_tasks[33:29],
    //        all_done[34]
    output logic [39:0]      m_tdata
);
    import mtcc_pkg::*;

    mtcc_cfg_t    cfg;
    mtcc_item_t   in_item_reg, in_item_next;
    logic         in_valid_reg, in_valid_next;
    mtcc_result_t result;
    mtcc_result_t out_data_reg, out_data_next;
    logic         out_valid_reg, out_valid_next;
    logic         fire;
    logic         in_take;

    mtcc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mtcc_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // handshake: evaluate when the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign in_take  = s_tvalid && s_tready;

    // input register next state
    always_comb
    begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next              = 1'b1;
            in_item_next.opcode         = s_tuser;
            in_item_next.task_id        = s_tdata[2:0];
            in_item_next.task_target    = s_tdata[18:3];
            in_item_next.drive_encoder  = s_tdata[34:19];
            in_item_next.claw_sensor    = s_tdata[50:35];
            in_item_next.arm_sensor     = s_tdata[66:51];
            in_item_next.heading_sensor = s_tdata[82:67];
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // result register next state
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_data_reg <= out_data_next;
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_data_reg.all_done,
                       out_data_reg.active_tasks,
                       out_data_reg.turn_drive_speed,
                       out_data_reg.turn_action,
                       out_data_reg.arm_drive_speed,
                       out_data_reg.arm_action,
                       out_data_reg.claw_drive_speed,
                       out_data_reg.claw_action,
                       out_data_reg.encoder_reset,
                       out_data_reg.drive_stop};

endmodule

`default_nettype wire

// ===== tb/multi_axis_task_completion_controller_test.sv =====
// ----------------------------------------------------------------------------
// multi_axis_task_completion_controller_test
// Stream-level regression for the five-task motion completion tracker. A
// model of the task table runs beside the block and predicts the motor
// commands for every accepted transfer. Directed start and tick sequences
// come first. Random sequences follow under several register settings, with
// random idle cycles on both sides and a long output stall.
// ----------------------------------------------------------------------------
module multi_axis_task_completion_controller_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mtcc_pkg::*;

    // task ids the block must ignore on a start
    localparam logic [2:0] TASK_BAD_FIRST = 3'd5;
    localparam logic [2:0] TASK_BAD_LAST  = 3'd7;
    // register index with no register behind it
    localparam logic [2:0] CFG_UNUSED     = 3'd7;
    // idle cycles waited after the last expected result
    localparam int         SETTLE_CYCLES  = 4;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    // task table model and its register copy
    logic [4:0]   active_mask;
    int           drive_goal;
    int           claw_goal;
    int           arm_goal;
    int           heading_goal;
    int           claw_last;
    int           claw_thr;
    int           arm_thr;
    int           heading_thr;
    int           claw_speed;
    int           lift_speed;
    int           turn_speed;
    int           claw_closed;

    mtcc_result_t predicted_cmds[$];
    int           mismatches;
    int           results_seen;
    int           hold_rx;
    bit           steady;

    multi_axis_task_completion_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("multi_axis_task_completion_controller regression: fail");
        $finish;
    end

    task automatic log_error(input string msg);
        mismatches++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            log_error($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
    endtask

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // model of one item: updates the task table, returns the motor commands
    function automatic mtcc_result_t advance_tasks(input mtcc_item_t it);
        mtcc_result_t r;
        int           enc;
        int           claw;
        int           arm;
        int           head;
        int           err;
        int           err_mag;
        int           spd;
        bit           still;
        r = '0;
        if (it.opcode == OP_START)
        begin
            if (it.task_id <= TASK_HEADING)
            begin
                active_mask[it.task_id] = 1'b1;
                case (it.task_id)
                    TASK_DRIVE:   drive_goal   = $signed(it.task_target);
                    TASK_CLAW:    claw_goal    = $signed(it.task_target);
                    TASK_ARM:     arm_goal     = $signed(it.task_target);
                    TASK_HEADING: heading_goal = $signed(it.task_target);
                    default: ;
                endcase
            end
        end
        else
        begin
            enc  = $signed(it.drive_encoder);
            claw = $signed(it.claw_sensor);
            arm  = $signed(it.arm_sensor);
            head = $signed(it.heading_sensor);

            // drive: done once the encoder passes a nonzero target
            if (active_mask[TASK_DRIVE] &&
                ((drive_goal > 0 && enc > drive_goal) ||
                 (drive_goal < 0 && enc < drive_goal)))
            begin
                r.drive_stop    = 1'b1;
                r.encoder_reset = 1'b1;
                active_mask[TASK_DRIVE] = 1'b0;
                drive_goal = 0;
            end

            // claw position with distance bands
            if (active_mask[TASK_CLAW])
            begin
                err     = claw_goal - claw;
                err_mag = magnitude(err);
                if (err_mag > claw_thr)
                begin
                    spd = claw_speed;
                    if (err_mag < CLAW_BAND_FINE)        spd = spd / 8;
                    else if (err_mag < CLAW_BAND_MID)    spd = spd / 4;
                    else if (err_mag < CLAW_BAND_COARSE) spd = spd / 2;
                    r.claw_action      = (err > 0) ? CLAW_OPEN : CLAW_CLOSE;
                    r.claw_drive_speed = spd[6:0];
                end
                else
                begin
                    r.claw_action = CLAW_STOP;
                    active_mask[TASK_CLAW] = 1'b0;
                end
            end

            // tightening: stall or near closed, overrides the position command once done
            if (active_mask[TASK_TIGHTEN])
            begin
                still = magnitude(claw_last - claw) <= STALL_LIMIT;
                claw_last = claw;
                if (still || magnitude(claw - claw_closed) < claw_thr)
                begin
                    r.claw_action      = CLAW_STOP;
                    r.claw_drive_speed = '0;
                    claw_last = 0;
                    active_mask[TASK_TIGHTEN] = 1'b0;
                end
            end

            // arm: drop starts from a third of the lift speed
            if (active_mask[TASK_ARM])
            begin
                err     = arm_goal - arm;
                err_mag = magnitude(err);
                if (err_mag > arm_thr)
                begin
                    spd = (err > 0) ? lift_speed : lift_speed / 3;
                    if (err_mag < ARM_BAND_FINE)        spd = spd / 3;
                    else if (err_mag < ARM_BAND_COARSE) spd = spd / 2;
                    r.arm_action      = (err > 0) ? ARM_LIFT : ARM_DROP;
                    r.arm_drive_speed = spd[6:0];
                end
                else
                begin
                    r.arm_action = ARM_STOP;
                    active_mask[TASK_ARM] = 1'b0;
                end
            end

            // heading: done stops the base
            if (active_mask[TASK_HEADING])
            begin
                err     = heading_goal - head;
                err_mag = magnitude(err);
                if (err_mag > heading_thr)
                begin
                    spd = turn_speed;
                    if (err_mag < TURN_BAND_FINE)        spd = spd / 4;
                    else if (err_mag < TURN_BAND_COARSE) spd = spd / 2;
                    r.turn_action      = (err > 0) ? TURN_CW : TURN_CCW;
                    r.turn_drive_speed = spd[6:0];
                end
                else
                begin
                    r.drive_stop = 1'b1;
                    active_mask[TASK_HEADING] = 1'b0;
                end
            end
        end
        r.active_tasks = active_mask;
        r.all_done     = (active_mask == '0);
        return r;
    endfunction

    // register writes, input transfers and result transfers
    always @(posedge clk)
    begin : monitor
        mtcc_item_t   it;
        mtcc_result_t got;
        mtcc_result_t want;
        if (!rst_n)
        begin
            active_mask  = '0;
            drive_goal   = 0;
            claw_goal    = 0;
            arm_goal     = 0;
            heading_goal = 0;
            claw_last    = 0;
            claw_thr     = 50;
            arm_thr      = 50;
            heading_thr  = 20;
            claw_speed   = 127;
            lift_speed   = 127;
            turn_speed   = 127;
            claw_closed  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLAW_THRESHOLD:    claw_thr    = int'(cfg_wdata[11:0]);
                    CFG_ARM_THRESHOLD:     arm_thr     = int'(cfg_wdata[11:0]);
                    CFG_HEADING_THRESHOLD: heading_thr = int'(cfg_wdata[11:0]);
                    CFG_CLAW_FULL_SPEED:   claw_speed  = int'(cfg_wdata[6:0]);
                    CFG_LIFT_FULL_SPEED:   lift_speed  = int'(cfg_wdata[6:0]);
                    CFG_TURN_FULL_SPEED:   turn_speed  = int'(cfg_wdata[6:0]);
                    CFG_CLAW_CLOSED_POS:   claw_closed = int'($signed(cfg_wdata));
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                it.opcode         = s_tuser;
                it.task_id        = s_tdata[2:0];
                it.task_target    = s_tdata[18:3];
                it.drive_encoder  = s_tdata[34:19];
                it.claw_sensor    = s_tdata[50:35];
                it.arm_sensor     = s_tdata[66:51];
                it.heading_sensor = s_tdata[82:67];
                predicted_cmds.push_back(advance_tasks(it));
            end

            if (m_tvalid && m_tready)
            begin
                got.drive_stop       = m_tdata[0];
                got.encoder_reset    = m_tdata[1];
                got.claw_action      = m_tdata[3:2];
                got.claw_drive_speed = m_tdata[10:4];
                got.arm_action       = m_tdata[12:11];
                got.arm_drive_speed  = m_tdata[19:13];
                got.turn_action      = m_tdata[21:20];
                got.turn_drive_speed = m_tdata[28:22];
                got.active_tasks     = m_tdata[33:29];
                got.all_done         = m_tdata[34];
                if (predicted_cmds.size() == 0)
                begin
                    log_error($sformatf("result %0d with nothing expected", results_seen));
                end
                else
                begin
                    want = predicted_cmds.pop_front();
                    check_field("drive_stop", got.drive_stop, want.drive_stop);
                    check_field("encoder_reset", got.encoder_reset, want.encoder_reset);
                    check_field("claw_action", got.claw_action, want.claw_action);
                    check_field("claw_drive_speed", got.claw_drive_speed,
                                want.claw_drive_speed);
                    check_field("arm_action", got.arm_action, want.arm_action);
                    check_field("arm_drive_speed", got.arm_drive_speed,
                                want.arm_drive_speed);
                    check_field("turn_action", got.turn_action, want.turn_action);
                    check_field("turn_drive_speed", got.turn_drive_speed,
                                want.turn_drive_speed);
                    check_field("active_tasks", got.active_tasks, want.active_tasks);
                    check_field("all_done", got.all_done, want.all_done);
                end
                results_seen++;
            end
        end
    end

    // output side: random stall per transfer, plus long hold-off on request
    initial
    begin : receiver
        int rx_wait;
        m_tready = 1'b0;
        rx_wait  = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                rx_wait = steady ? 0 : $urandom_range(0, 9);
            @(negedge clk);
            if (hold_rx > 0)
            begin
                m_tready = 1'b0;
                hold_rx--;
            end
            else if (rx_wait > 0)
            begin
                m_tready = 1'b0;
                rx_wait--;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // one input transfer, after a random gap
    task automatic send_item(input mtcc_item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = it.opcode;
        s_tdata  = {5'd0, it.heading_sensor, it.arm_sensor, it.claw_sensor,
                    it.drive_encoder, it.task_target, it.task_id};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic start_task(input logic [2:0] id, input int target);
        mtcc_item_t it;
        it = '0;
        it.opcode      = OP_START;
        it.task_id     = id;
        it.task_target = target[15:0];
        send_item(it);
    endtask

    task automatic tick(input int enc, input int claw, input int arm, input int head);
        mtcc_item_t it;
        it = '0;
        it.opcode         = OP_TICK;
        it.drive_encoder  = enc[15:0];
        it.claw_sensor    = claw[15:0];
        it.arm_sensor     = arm[15:0];
        it.heading_sensor = head[15:0];
        send_item(it);
    endtask

    // stop sending and wait for every expected result
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (predicted_cmds.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic load_settings(input logic [15:0] c_thr, input logic [15:0] a_thr,
                                 input logic [15:0] h_thr, input logic [15:0] c_spd,
                                 input logic [15:0] l_spd, input logic [15:0] t_spd,
                                 input logic [15:0] closed);
        write_reg(CFG_CLAW_THRESHOLD, c_thr);
        write_reg(CFG_ARM_THRESHOLD, a_thr);
        write_reg(CFG_HEADING_THRESHOLD, h_thr);
        write_reg(CFG_CLAW_FULL_SPEED, c_spd);
        write_reg(CFG_LIFT_FULL_SPEED, l_spd);
        write_reg(CFG_TURN_FULL_SPEED, t_spd);
        write_reg(CFG_CLAW_CLOSED_POS, closed);
    endtask

    // value near a center in one of several distance bands, or any value
    function automatic logic [15:0] around(input int center);
        int off;
        int v;
        case ($urandom_range(0, 5))
            0: off = $urandom_range(0, 5);
            1: off = $urandom_range(0, 60);
            2: off = $urandom_range(0, 300);
            3: off = $urandom_range(0, 700);
            4: off = $urandom_range(0, 1500);
            default: return 16'($urandom);
        endcase
        v = $urandom_range(0, 1) ? center + off : center - off;
        if (v > 32767)  v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // threshold draw: mostly small, sometimes anywhere in range
    function automatic logic [15:0] random_threshold();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 4095));
        return 16'($urandom_range(0, 200));
    endfunction

    // mostly ticks that close in on the current targets, some starts
    function automatic mtcc_item_t random_item();
        mtcc_item_t it;
        int         pick;
        it.task_id        = 3'($urandom);
        it.task_target    = 16'($urandom);
        it.drive_encoder  = 16'($urandom);
        it.claw_sensor    = 16'($urandom);
        it.arm_sensor     = 16'($urandom);
        it.heading_sensor = 16'($urandom);
        if ($urandom_range(0, 3) == 0 || (active_mask == '0 && $urandom_range(0, 1) == 0))
        begin
            it.opcode = OP_START;
            if ($urandom_range(0, 15) == 0)
                it.task_id = 3'($urandom_range(TASK_BAD_FIRST, TASK_BAD_LAST));
            else
                it.task_id = 3'($urandom_range(TASK_DRIVE, TASK_HEADING));
            if ($urandom_range(0, 3) != 0)
                it.task_target = around(0);
        end
        else
        begin
            it.opcode         = OP_TICK;
            it.drive_encoder  = around(drive_goal);
            pick              = $urandom_range(0, 2);
            it.claw_sensor    = around(pick == 0 ? claw_goal :
                                       pick == 1 ? claw_last : claw_closed);
            it.arm_sensor     = around(arm_goal);
            it.heading_sensor = around(heading_goal);
        end
        return it;
    endfunction

    task automatic run_random(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 99) == 0)
                steady = !steady;
            if ($urandom_range(0, 149) == 0)
                wait_drained();
            send_item(random_item());
        end
    endtask

    // hand-picked sequences at reset settings
    task automatic test_directed();
        tick(0, 0, 0, 0);
        start_task(TASK_BAD_FIRST, 100);
        start_task(TASK_BAD_LAST, -1);
        // drive positive, negative, zero target
        start_task(TASK_DRIVE, 100);
        tick(100, 0, 0, 0);
        tick(101, 0, 0, 0);
        start_task(TASK_DRIVE, -32768);
        tick(-32768, 0, 0, 0);
        start_task(TASK_DRIVE, 0);
        tick(32767, 0, 0, 0);
        start_task(TASK_DRIVE, -5);
        tick(-6, 0, 0, 0);
        // largest errors on all axes, then a claw stall
        start_task(TASK_CLAW, 32767);
        start_task(TASK_ARM, -32768);
        start_task(TASK_HEADING, 32767);
        start_task(TASK_TIGHTEN, 12345);
        tick(0, -32768, 32767, -32768);
        tick(0, -32766, 32767, -32768);
        // both claw tasks stop together near closed
        start_task(TASK_CLAW, 0);
        start_task(TASK_TIGHTEN, 0);
        tick(0, 200, 32767, -32768);
        tick(0, 30, 32767, -32768);
        // arm bands in both directions
        start_task(TASK_ARM, 800);
        tick(0, 0, 0, -32768);
        tick(0, 0, 400, -32768);
        tick(0, 0, 1000, -32768);
        tick(0, 0, 760, -32768);
        // heading bands, then done
        start_task(TASK_HEADING, -500);
        tick(0, 0, 0, 0);
        tick(0, 0, 0, -250);
        tick(0, 0, 0, -490);
        wait_drained();
    endtask

    // every register at its top and bottom values, masked writes
    task automatic test_register_extremes();
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        write_reg(CFG_UNUSED, 16'hFFFF);
        run_random(60);
        wait_drained();
        load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
        run_random(60);
        wait_drained();
        load_settings(16'd50, 16'd50, 16'd20, 16'd127, 16'd127, 16'd127, 16'd0);
    endtask

    // output held off while the input keeps offering
    task automatic test_backpressure();
        hold_rx = 80;
        steady  = 1'b1;
        run_random(30);
        steady  = 1'b0;
        wait_drained();
    endtask

    // random sequences under several register settings
    task automatic test_random_phases();
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase > 0)
                load_settings(random_threshold(), random_threshold(), random_threshold(),
                              16'($urandom_range(0, 127)), 16'($urandom_range(0, 127)),
                              16'($urandom_range(0, 127)), around(0));
            run_random(220);
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_TICK;
        mismatches   = 0;
        results_seen = 0;
        hold_rx      = 0;
        steady       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random_phases();
        wait_drained();

        if (mismatches == 0)
            $display("multi_axis_task_completion_controller regression: pass");
        else
            $display("multi_axis_task_completion_controller regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mtcc_pkg.sv
hw/rtl/mtcc_cfg_regs.sv
hw/rtl/mtcc_tracker.sv
hw/rtl/multi_axis_task_completion_controller.sv
tb/multi_axis_task_completion_controller_test.sv
